### rtl/core/chsd_pkg.sv
// ----------------------------------------------------------------------------
// chsd_pkg
// Shared types and constants for the chamber hit select and duplicate block.
// ----------------------------------------------------------------------------
package chsd_pkg;

   localparam int LINK_COUNT   = 54;
   localparam int LINK_W       = 6;
   localparam int STORE_DEPTH  = LINK_COUNT * 2;
   localparam int ENTRY_W      = 23;
   localparam int REQ_FIELDS_W = 51;
   localparam int REQ_DATA_W   = 56;
   localparam int RSP_FIELDS_W = 31;
   localparam int RSP_DATA_W   = 32;
   localparam int CSR_IDX_W    = 3;
   localparam int CSR_DATA_W   = 5;

   // first link of the neighbor-sector chambers
   localparam logic [LINK_W-1:0] LINK_NB_BASE = 6'd45;
   localparam logic [LINK_W-1:0] CHAMBERS_PER_STATION = 6'd9;

   // pattern and quality patching
   localparam logic [3:0] PAT_PATCH_A = 4'd11;
   localparam logic [3:0] PAT_PATCH_B = 4'd12;
   localparam logic [3:0] PAT_PATCHED = 4'd10;
   localparam logic [3:0] QUAL_ZERO   = 4'd0;
   localparam logic [3:0] QUAL_MIN    = 4'd1;

   // configuration register indexes
   localparam logic [CSR_IDX_W-1:0] REG_OWN_ENDCAP  = 3'd0;
   localparam logic [CSR_IDX_W-1:0] REG_OWN_SECTOR  = 3'd1;
   localparam logic [CSR_IDX_W-1:0] REG_CUR_SLOT    = 3'd2;
   localparam logic [CSR_IDX_W-1:0] REG_SLOT_SHIFT  = 3'd3;
   localparam logic [CSR_IDX_W-1:0] REG_NB_ENABLE   = 3'd4;
   localparam logic [CSR_IDX_W-1:0] REG_PAIR_ENABLE = 3'd5;
   localparam logic [CSR_IDX_W-1:0] REG_FORCE_INNER = 3'd6;

   // input item fields, first field in the highest bits
   typedef struct packed {
      logic [5:0] drain_link;
      logic [3:0] quality;
      logic [3:0] pattern;
      logic [6:0] keywire;
      logic [7:0] strip;
      logic [3:0] chamber_id;
      logic [3:0] hit_slot;
      logic [5:0] chamber;
      logic [2:0] station;
      logic [2:0] hit_sector;
      logic [1:0] hit_endcap;
   } req_type;

   // stored hit
   typedef struct packed {
      logic [3:0] quality;
      logic [3:0] pattern;
      logic [6:0] keywire;
      logic [7:0] strip;
   } entry_type;

   // result item fields carried in tdata
   typedef struct packed {
      logic [3:0]        quality;
      logic [3:0]        pattern;
      logic [6:0]        keywire;
      logic [7:0]        strip;
      logic              dropped;
      logic              accepted;
      logic [LINK_W-1:0] link;
   } rsp_type;

   typedef struct packed {
      logic capture;
      logic offer_commit;
      logic drain_empty;
      logic drain_start;
      logic lat_a;
      logic lat_b;
      logic emit;
   } cmd_type;

   typedef struct packed {
      logic is_drain;
      logic drain_nonempty;
      logic fill_two;
      logic out_free;
      logic pair_last;
   } sts_type;

endpackage

### rtl/core/chsd_ram.sv
// ----------------------------------------------------------------------------
// chsd_ram
// Generic single-port-write, single-port-read RAM with registered read data.
// ----------------------------------------------------------------------------
module chsd_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wen,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic                     ren,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (wen) begin
         mem_ff[waddr] <= wdata;
      end
      if (ren) begin
         rdata_ff <= mem_ff[raddr];
      end
   end

   assign rdata = rdata_ff;

endmodule

### rtl/core/chsd_ctrl.sv
// ----------------------------------------------------------------------------
// chsd_ctrl
// Sequencer: takes one item, evaluates it, reads a drained link if needed and emits.
// ----------------------------------------------------------------------------
module chsd_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_tvalid,
   output logic              req_tready,
   input  chsd_pkg::sts_type sts,
   output chsd_pkg::cmd_type cmd
);
   import chsd_pkg::*;

   typedef enum logic [4:0] {
      S_IDLE = 5'b00001,
      S_EVAL = 5'b00010,
      S_RDA  = 5'b00100,
      S_RDB  = 5'b01000,
      S_EMIT = 5'b10000
   } state_type;

   state_type state_ff, state_in;

   always_comb begin
      state_in   = state_ff;
      cmd        = '0;
      req_tready = 1'b0;
      unique case (state_ff)
         S_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               cmd.capture = 1'b1;
               state_in    = S_EVAL;
            end
         end
         S_EVAL: begin
            if (sts.is_drain) begin
               if (sts.drain_nonempty) begin
                  cmd.drain_start = 1'b1;
                  state_in        = S_RDA;
               end else if (sts.out_free) begin
                  cmd.drain_empty = 1'b1;
                  state_in        = S_IDLE;
               end
            end else if (sts.out_free) begin
               cmd.offer_commit = 1'b1;
               state_in         = S_IDLE;
            end
         end
         S_RDA: begin
            cmd.lat_a = 1'b1;
            state_in  = sts.fill_two ? S_RDB : S_EMIT;
         end
         S_RDB: begin
            cmd.lat_b = 1'b1;
            state_in  = S_EMIT;
         end
         S_EMIT: begin
            if (sts.out_free) begin
               cmd.emit = 1'b1;
               if (sts.pair_last) begin
                  state_in = S_IDLE;
               end
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

### rtl/core/chsd_dp.sv
// ----------------------------------------------------------------------------
// chsd_dp
// Datapath: config registers, hit selection and link map, fill counts,
// entry store, pairing and the output register.
// ----------------------------------------------------------------------------
module chsd_dp (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                csr_wen,
   input  logic [chsd_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [chsd_pkg::CSR_DATA_W-1:0]     csr_wdata,
   input  logic                                req_tuser,
   input  logic [chsd_pkg::REQ_DATA_W-1:0]     req_tdata,
   input  logic                                rsp_tready,
   output logic                                rsp_tvalid,
   output logic                                rsp_tuser,
   output logic [chsd_pkg::RSP_DATA_W-1:0]     rsp_tdata,
   output logic                                rsp_tlast,
   input  chsd_pkg::cmd_type                   cmd,
   output chsd_pkg::sts_type                   sts
);
   import chsd_pkg::*;

   localparam int ADDR_W = $clog2(STORE_DEPTH);

   // configuration
   logic [1:0] own_endcap_ff;
   logic [2:0] own_sector_ff;
   logic [4:0] cur_slot_ff;
   logic [4:0] slot_shift_ff;
   logic       nb_en_ff;
   logic       pair_en_ff;
   logic       force_inner_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         own_endcap_ff  <= 2'd1;
         own_sector_ff  <= 3'd1;
         cur_slot_ff    <= 5'd0;
         slot_shift_ff  <= 5'd0;
         nb_en_ff       <= 1'b1;
         pair_en_ff     <= 1'b1;
         force_inner_ff <= 1'b0;
      end else if (csr_wen) begin
         unique case (csr_index)
            REG_OWN_ENDCAP:  own_endcap_ff  <= csr_wdata[1:0];
            REG_OWN_SECTOR:  own_sector_ff  <= csr_wdata[2:0];
            REG_CUR_SLOT:    cur_slot_ff    <= csr_wdata;
            REG_SLOT_SHIFT:  slot_shift_ff  <= csr_wdata;
            REG_NB_ENABLE:   nb_en_ff       <= csr_wdata[0];
            REG_PAIR_ENABLE: pair_en_ff     <= csr_wdata[0];
            REG_FORCE_INNER: force_inner_ff <= csr_wdata[0];
            default: ;
         endcase
      end
   end

   // captured item
   logic    op_ff;
   req_type req_ff;

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         op_ff  <= req_tuser;
         req_ff <= req_type'(req_tdata[REQ_FIELDS_W-1:0]);
      end
   end

   // hit selection and link map
   logic [11:0]       cham_prod;
   logic [3:0]        cham_div6;
   logic [5:0]        cham_rem;
   logic              sub_one;
   logic [6:0]        slot_sum;
   logic              slot_ok;
   logic              base_ok;
   logic [3:0]        id_m1;
   logic              own_hit;
   logic [2:0]        nb_sector;
   logic              nb_hit;
   logic              id3, id6, id9;
   logic [LINK_W-1:0] own_link;
   logic [LINK_W-1:0] nb_link;
   logic              nb_ok;
   logic              hit_sel;
   logic [LINK_W-1:0] link_sel;

   always_comb begin
      // chamber mod 6 through multiply by 43/256, exact below 128
      cham_prod = {6'd0, req_ff.chamber} * 12'd43;
      cham_div6 = cham_prod[11:8];
      cham_rem  = req_ff.chamber - 6'({2'd0, cham_div6} * 6'd6);
      sub_one   = cham_rem > 6'd2;

      slot_sum = {3'd0, req_ff.hit_slot} + {{2{slot_shift_ff[4]}}, slot_shift_ff};
      slot_ok  = slot_sum == {{2{cur_slot_ff[4]}}, cur_slot_ff};
      base_ok  = req_ff.station >= 3'd1 && req_ff.station <= 3'd4
                 && req_ff.chamber_id >= 4'd1 && req_ff.chamber_id <= 4'd9;
      id_m1    = req_ff.chamber_id - 4'd1;
      id3      = req_ff.chamber_id == 4'd3;
      id6      = req_ff.chamber_id == 4'd6;
      id9      = req_ff.chamber_id == 4'd9;

      own_hit = req_ff.hit_endcap == own_endcap_ff && req_ff.hit_sector == own_sector_ff;
      if (req_ff.station == 3'd1) begin
         own_link = sub_one ? {2'd0, id_m1} : CHAMBERS_PER_STATION + {2'd0, id_m1};
      end else begin
         own_link = 6'({3'd0, req_ff.station} * CHAMBERS_PER_STATION) + {2'd0, id_m1};
      end

      // sector 0 has no neighbor
      nb_sector = (own_sector_ff == 3'd1) ? 3'd6 : own_sector_ff - 3'd1;
      nb_hit    = nb_en_ff && req_ff.hit_endcap == own_endcap_ff
                  && own_sector_ff != 3'd0 && req_ff.hit_sector == nb_sector;
      if (req_ff.station == 3'd1) begin
         nb_ok   = !sub_one && (id3 || id6 || id9);
         nb_link = LINK_NB_BASE + (id3 ? 6'd0 : (id6 ? 6'd1 : 6'd2));
      end else begin
         nb_ok   = id3 || id9;
         nb_link = LINK_NB_BASE - 6'd1 + {2'd0, req_ff.station, 1'b0} + {5'd0, id9};
      end

      hit_sel  = base_ok && slot_ok && (own_hit || (nb_hit && nb_ok));
      link_sel = !hit_sel ? '0 : (own_hit ? own_link : nb_link);
   end

   // fill counts
   logic [1:0]        fill_ff [LINK_COUNT];
   logic [LINK_W-1:0] rd_link;
   logic              rd_in_range;
   logic [1:0]        fill_rd;
   logic              store_wen;

   always_comb begin
      rd_link     = op_ff ? req_ff.drain_link : link_sel;
      rd_in_range = rd_link < LINK_W'(LINK_COUNT);
      fill_rd     = rd_in_range ? fill_ff[rd_link] : 2'd0;
      store_wen   = cmd.offer_commit && hit_sel && !fill_rd[1];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < LINK_COUNT; i++) begin
            fill_ff[i] <= 2'd0;
         end
      end else if (store_wen) begin
         fill_ff[link_sel] <= fill_rd + 2'd1;
      end else if (cmd.drain_start) begin
         fill_ff[req_ff.drain_link] <= 2'd0;
      end
   end

   // entry store
   entry_type             new_entry;
   logic [ENTRY_W-1:0]    ram_rdata;
   entry_type             rd_entry;

   always_comb begin
      new_entry.strip   = req_ff.strip;
      new_entry.keywire = req_ff.keywire;
      new_entry.pattern = (req_ff.pattern == PAT_PATCH_A || req_ff.pattern == PAT_PATCH_B)
                          ? PAT_PATCHED : req_ff.pattern;
      new_entry.quality = (req_ff.quality == QUAL_ZERO) ? QUAL_MIN : req_ff.quality;
      rd_entry          = entry_type'(ram_rdata);
   end

   chsd_ram #(
      .WIDTH(ENTRY_W),
      .DEPTH(STORE_DEPTH)
   ) u_store (
      .clock(clock),
      .wen  (store_wen),
      .waddr(ADDR_W'({link_sel, fill_rd[0]})),
      .wdata(new_entry),
      .ren  (cmd.drain_start || cmd.lat_a),
      .raddr(ADDR_W'({req_ff.drain_link, cmd.lat_a})),
      .rdata(ram_rdata)
   );

   // drain and pairing
   logic      fill_two_ff;
   entry_type a_ff, b_ff;
   logic      four_ff, four_in;
   logic [1:0] idx_ff, last_idx_ff;
   logic      differ, inner;

   always_comb begin
      differ  = a_ff.strip != rd_entry.strip && a_ff.keywire != rd_entry.keywire;
      inner   = req_ff.drain_link <= 6'd2
                || (req_ff.drain_link >= 6'd9 && req_ff.drain_link <= 6'd11)
                || req_ff.drain_link == LINK_NB_BASE;
      four_in = pair_en_ff && (differ || (force_inner_ff && inner));
   end

   always_ff @(posedge clock) begin
      if (cmd.drain_start) begin
         fill_two_ff <= fill_rd[1];
      end
      if (cmd.lat_a) begin
         a_ff        <= rd_entry;
         four_ff     <= 1'b0;
         last_idx_ff <= 2'd0;
         idx_ff      <= 2'd0;
      end
      if (cmd.lat_b) begin
         b_ff        <= rd_entry;
         four_ff     <= four_in;
         last_idx_ff <= four_in ? 2'd3 : 2'd1;
      end
      if (cmd.emit) begin
         idx_ff <= idx_ff + 2'd1;
      end
   end

   // pairing k: strip side from b on odd k, wire side from b on k >= 2 in four mode
   logic      strip_b, wire_b;
   entry_type sp_src;
   entry_type emit_entry;

   always_comb begin
      strip_b            = idx_ff[0];
      wire_b             = four_ff ? idx_ff[1] : idx_ff[0];
      sp_src             = strip_b ? b_ff : a_ff;
      emit_entry         = sp_src;
      emit_entry.keywire = wire_b ? b_ff.keywire : a_ff.keywire;
   end

   // output register
   logic    out_valid_ff, out_valid_in;
   logic    out_entry_ff, out_last_ff;
   rsp_type out_ff, out_in;
   logic    out_entry_in, out_last_in;
   logic    out_free;

   always_comb begin
      out_free     = !out_valid_ff || rsp_tready;
      out_in       = '0;
      out_entry_in = 1'b0;
      out_last_in  = 1'b1;
      if (cmd.offer_commit) begin
         out_in.link     = link_sel;
         out_in.accepted = hit_sel;
         out_in.dropped  = hit_sel && fill_rd[1];
      end else if (cmd.drain_empty) begin
         out_in.link = req_ff.drain_link;
      end else begin
         out_in.link    = req_ff.drain_link;
         out_in.strip   = emit_entry.strip;
         out_in.keywire = emit_entry.keywire;
         out_in.pattern = emit_entry.pattern;
         out_in.quality = emit_entry.quality;
         out_entry_in   = 1'b1;
         out_last_in    = idx_ff == last_idx_ff;
      end
      if (cmd.offer_commit || cmd.drain_empty || cmd.emit) begin
         out_valid_in = 1'b1;
      end else if (rsp_tready) begin
         out_valid_in = 1'b0;
      end else begin
         out_valid_in = out_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.offer_commit || cmd.drain_empty || cmd.emit) begin
         out_ff       <= out_in;
         out_entry_ff <= out_entry_in;
         out_last_ff  <= out_last_in;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tuser  = out_entry_ff;
   assign rsp_tlast  = out_last_ff;
   assign rsp_tdata  = {{(RSP_DATA_W - RSP_FIELDS_W){1'b0}}, out_ff};

   always_comb begin
      sts.is_drain       = op_ff;
      sts.drain_nonempty = rd_in_range && fill_rd != 2'd0;
      sts.fill_two       = fill_two_ff;
      sts.out_free       = out_free;
      sts.pair_last      = idx_ff == last_idx_ff;
   end

endmodule

### rtl/core/chamber_hit_select_and_duplicate_top.sv
// ----------------------------------------------------------------------------
// chamber_hit_select_and_duplicate_top
// Selects chamber hits into per-link slots and drains links with pairings.
// ----------------------------------------------------------------------------
// Offer: the captured item's result is registered once the output register is free; the next item is taken after that.
// Drain: the entry store is read through its single registered read port, latching entry a and, for two
//   stored hits, entry b; then one result per cycle while the output is not stalled (1,2,4).
// Empty or out-of-range drain: one result, registered once the output register is free.
// Reset (synchronous) clears fill counts and control and loads the configuration defaults; the
//   entry store is not cleared and needs no sweep.
module chamber_hit_select_and_duplicate_top (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            csr_wen,
   input  logic [chsd_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [chsd_pkg::CSR_DATA_W-1:0] csr_wdata,
   input  logic                            req_tvalid,
   output logic                            req_tready,
   // tuser: operation
   input  logic                            req_tuser,
   // tdata: hit_endcap, hit_sector, station, chamber, hit_slot, chamber_id,
   //        strip, keywire, pattern, quality, drain_link
   input  logic [chsd_pkg::REQ_DATA_W-1:0] req_tdata,
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   // tuser: entry_valid
   output logic                            rsp_tuser,
   // tdata: link, accepted, dropped, out_strip, out_keywire, out_pattern,
   //        out_quality
   output logic [chsd_pkg::RSP_DATA_W-1:0] rsp_tdata,
   output logic                            rsp_tlast
);
   import chsd_pkg::*;

   cmd_type cmd;
   sts_type sts;

   chsd_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .sts       (sts),
      .cmd       (cmd)
   );

   chsd_dp u_dp (
      .clock     (clock),
      .reset     (reset),
      .csr_wen   (csr_wen),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .req_tuser (req_tuser),
      .req_tdata (req_tdata),
      .rsp_tready(rsp_tready),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tuser (rsp_tuser),
      .rsp_tdata (rsp_tdata),
      .rsp_tlast (rsp_tlast),
      .cmd       (cmd),
      .sts       (sts)
   );

endmodule

### rtl/core/chsd_checker.sv
// ----------------------------------------------------------------------------
// chsd_checker
// Port-level checks on the result stream, bound to the top level.
// ----------------------------------------------------------------------------
module chsd_checker (
   input logic                            clock,
   input logic                            reset,
   input logic                            req_tvalid,
   input logic                            req_tready,
   input logic                            rsp_tvalid,
   input logic                            rsp_tready,
   input logic                            rsp_tuser,
   input logic [chsd_pkg::RSP_DATA_W-1:0] rsp_tdata,
   input logic                            rsp_tlast
);
   import chsd_pkg::*;

   // stalled item holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata)
                                    && $stable(rsp_tlast) && $stable(rsp_tuser))
      else $error("result changed while stalled");

   // items without a hit entry are single results
   a_noentry_last: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tuser |-> rsp_tlast)
      else $error("non-entry result not marked last");

   // a drop only happens on a selected hit, never on a drained entry
   a_drop_flags: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[7] |-> rsp_tdata[6] && !rsp_tuser)
      else $error("dropped without accepted");

   a_reset_idle: assert property (@(posedge clock)
      reset |=> !rsp_tvalid && req_tready)
      else $error("not idle after reset");

endmodule

bind chamber_hit_select_and_duplicate_top chsd_checker u_chsd_checker (.*);
